@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each check is sampled on the rising
// edge of clock and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/swft_pkg.sv @@
`default_nettype none

package swft_pkg;

   typedef enum logic [1:0] {
      CMD_TEXT  = 2'd0,
      CMD_ARC   = 2'd1,
      CMD_FINAL = 2'd2,
      CMD_END   = 2'd3
   } cmd_type;

   localparam logic [7:0] APOS_CHAR = 8'h27;
   localparam logic [4:0] APOS_SYM  = 5'd26;
   localparam logic [7:0] CASE_DIFF = 8'h20;
   localparam logic [7:0] CHAR_A_LO = 8'h61;

   // Control handed from the tokenizer front end to the automaton.
   typedef struct packed {
      logic       start;
      logic       step;
      logic       finish;
      logic [4:0] sym;
      logic       wr_arc;
      logic       wr_fin;
      logic [7:0] tbl_state;
      logic [4:0] tbl_sym;
      logic [7:0] tbl_next;
      logic       arc;
      logic       fin;
   } dfa_ctl_type;

   // Verdict for a finished word, valid in the cycle after the finish.
   typedef struct packed {
      logic done;
      logic stop;
   } dfa_stat_type;

endpackage

`default_nettype wire

@@ rtl/swft_dfa.sv @@
`default_nettype none

module swft_dfa
   import swft_pkg::*;
#(
   parameter int NUM_STATES = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  dfa_ctl_type       ctl,
   output dfa_stat_type      stat
);

   localparam int TS     = (NUM_STATES > 256) ? 256 : NUM_STATES;
   localparam int SW     = (TS > 1) ? $clog2(TS) : 1;
   localparam int AW     = SW + 5;
   localparam int TDEPTH = (2 ** SW) * 32;
   localparam int FDEPTH = 2 ** SW;
   localparam logic [12:0] NUM_LIM = 13'(NUM_STATES);

   logic [8:0] trans_mem [TDEPTH];
   logic       final_mem [FDEPTH];

   logic [8:0] trans_rd_ff;
   logic       final_rd_ff;
   logic [7:0] state_ff,  state_in;
   logic       alive_ff,  alive_in;
   logic       pend_ff,   pend_in;
   logic       fpend_ff;
   logic       falive_ff;

   logic [7:0]    state_eff;
   logic          alive_eff;
   logic [7:0]    base_state;
   logic          base_alive;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          tbl_ok;

   // The previous character's lookup lands in trans_rd_ff in the following cycle, so the
   // current state is taken from the read data while a lookup is in flight.
   always_comb begin
      if (pend_ff) begin
         state_eff = trans_rd_ff[7:0];
         alive_eff = trans_rd_ff[8] && ({5'd0, trans_rd_ff[7:0]} < NUM_LIM);
      end else begin
         state_eff = state_ff;
         alive_eff = alive_ff;
      end
      base_state = ctl.start ? 8'd0 : state_eff;
      base_alive = ctl.start ? 1'b1 : alive_eff;
      rd_en      = ctl.step && base_alive;
      rd_addr    = {base_state[SW-1:0], ctl.sym};
      tbl_ok     = {5'd0, ctl.tbl_state} < NUM_LIM;
   end

   always_comb begin
      if (ctl.finish) begin
         state_in = 8'd0;
         alive_in = 1'b1;
         pend_in  = 1'b0;
      end else if (ctl.step) begin
         state_in = base_state;
         alive_in = base_alive;
         pend_in  = rd_en;
      end else begin
         state_in = state_eff;
         alive_in = alive_eff;
         pend_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= 8'd0;
         alive_ff <= 1'b1;
         pend_ff  <= 1'b0;
         fpend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         alive_ff <= alive_in;
         pend_ff  <= pend_in;
         fpend_ff <= ctl.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         falive_ff <= alive_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_arc && tbl_ok && (ctl.tbl_sym <= APOS_SYM)) begin
         trans_mem[{ctl.tbl_state[SW-1:0], ctl.tbl_sym}] <= {ctl.arc, ctl.tbl_next};
      end
      if (rd_en) begin
         trans_rd_ff <= trans_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_fin && tbl_ok) begin
         final_mem[ctl.tbl_state[SW-1:0]] <= ctl.fin;
      end
      if (ctl.finish) begin
         final_rd_ff <= final_mem[state_eff[SW-1:0]];
      end
   end

   assign stat.done = fpend_ff;
   assign stat.stop = falive_ff && final_rd_ff;

endmodule

`default_nettype wire

@@ rtl/stop_word_filter_tokenizer.sv @@
// A kept word passes from the verdict stage to the emitter and on to the output
// register, then leaves one character per cycle while the output is not stalled.
// Throughput: one byte per cycle; an item that ends a word stalls while the
// previous word's verdict is pending or it is still being read out of the word buffer.
// Reset: synchronous, active high; clears control state, tables need loading.
`default_nettype none

module stop_word_filter_tokenizer
   import swft_pkg::*;
#(
   parameter int NUM_STATES = 256,
   parameter int MAX_WORD   = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_cmd,
   input  wire logic [7:0] req_text_byte,
   input  wire logic [7:0] req_table_state,
   input  wire logic [4:0] req_table_symbol,
   input  wire logic [7:0] req_next_state,
   input  wire logic       req_arc_present,
   input  wire logic       req_final_mark,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_word_char,
   output logic            rsp_last_of_word,
   output logic            rsp_word_cut
);

`include "assert_macros.svh"

   // The word buffer holds two banks of MAX_WORD characters. One bank fills with
   // the incoming word while the other is read out by the emitter, so text keeps
   // flowing while a finished word is still being delivered.
   localparam int LW    = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int LENW  = $clog2(MAX_WORD + 1);
   localparam int BDEPTH = 2 * (2 ** LW);
   localparam logic [LENW-1:0] MAX_LEN = LENW'(MAX_WORD);

   logic [7:0] buf_mem [BDEPTH];

   cmd_type      cmd;
   dfa_ctl_type  dctl;
   dfa_stat_type dstat;

   logic          inside_ff,   inside_in;
   logic [LENW-1:0] len_ff,    len_in;
   logic          cut_ff,      cut_in;
   logic          wbank_ff,    wbank_in;
   logic [LENW-1:0] flen_ff;
   logic          fcut_ff;
   logic          fbank_ff;
   logic [LENW-1:0] emit_rem_ff, emit_rem_in;
   logic [LW-1:0] emit_idx_ff,  emit_idx_in;
   logic          emit_bank_ff;
   logic          emit_cut_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    buf_rd_ff;
   logic          rsp_last_ff;
   logic          rsp_cut_ff;

   logic            upper, lower, letter, apos;
   logic            is_text, is_finish, accept;
   logic            start, step, finish;
   logic [7:0]      ch;
   logic [LENW-1:0] len_eff;
   logic            room;
   logic            buf_we;
   logic            rd_en;
   logic            emit_load;

   assign cmd = cmd_type'(req_cmd);

   // Character classes. Bytes of 128 and up fall in no class and so act as
   // delimiters. An apostrophe only extends a word that has already started.
   always_comb begin
      upper   = (req_text_byte >= 8'h41) && (req_text_byte <= 8'h5A);
      lower   = (req_text_byte >= 8'h61) && (req_text_byte <= 8'h7A);
      letter  = upper || lower;
      apos    = req_text_byte == APOS_CHAR;
      is_text = cmd == CMD_TEXT;
      is_finish = inside_ff &&
                  ((is_text && !letter && !apos) || (cmd == CMD_END));
   end

   // A word end needs the emitter and the verdict stage free; everything else
   // is taken at once.
   assign req_stall = is_finish && (dstat.done || (emit_rem_ff != '0));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      start  = accept && is_text && !inside_ff && letter;
      step   = accept && is_text && (letter || (inside_ff && apos));
      finish = accept && is_finish;
      if (upper) begin
         ch = req_text_byte + CASE_DIFF;
      end else if (letter) begin
         ch = req_text_byte;
      end else begin
         ch = APOS_CHAR;
      end
      len_eff = start ? '0 : len_ff;
      room    = len_eff < MAX_LEN;
      buf_we  = step && room;
   end

   always_comb begin
      dctl.start     = start;
      dctl.step      = step;
      dctl.finish    = finish;
      dctl.sym       = letter ? 5'(ch - CHAR_A_LO) : APOS_SYM;
      dctl.wr_arc    = accept && (cmd == CMD_ARC);
      dctl.wr_fin    = accept && (cmd == CMD_FINAL);
      dctl.tbl_state = req_table_state;
      dctl.tbl_sym   = req_table_symbol;
      dctl.tbl_next  = req_next_state;
      dctl.arc       = req_arc_present;
      dctl.fin       = req_final_mark;
   end

   swft_dfa #(
      .NUM_STATES (NUM_STATES)
   ) u_dfa (
      .clock (clock),
      .reset (reset),
      .ctl   (dctl),
      .stat  (dstat)
   );

   // Word tracking. A character past the buffer is not stored but still steps
   // the automaton, and marks the word as cut.
   always_comb begin
      inside_in = inside_ff;
      len_in    = len_ff;
      cut_in    = cut_ff;
      wbank_in  = wbank_ff;
      if (finish) begin
         inside_in = 1'b0;
         len_in    = '0;
         cut_in    = 1'b0;
         wbank_in  = !wbank_ff;
      end else if (step) begin
         inside_in = 1'b1;
         len_in    = room ? len_eff + LENW'(1) : len_eff;
         cut_in    = (start ? 1'b0 : cut_ff) || !room;
      end
   end

   // Emitter. It reads one character per cycle into the output register, which
   // only advances when it is empty or being taken.
   assign emit_load = dstat.done && !dstat.stop;
   assign rd_en     = (emit_rem_ff != '0) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      emit_rem_in = emit_rem_ff;
      emit_idx_in = emit_idx_ff;
      if (emit_load) begin
         emit_rem_in = flen_ff;
         emit_idx_in = '0;
      end else if (rd_en) begin
         emit_rem_in = emit_rem_ff - LENW'(1);
         emit_idx_in = emit_idx_ff + LW'(1);
      end
      if (rd_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff    <= 1'b0;
         len_ff       <= '0;
         cut_ff       <= 1'b0;
         wbank_ff     <= 1'b0;
         emit_rem_ff  <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inside_ff    <= inside_in;
         len_ff       <= len_in;
         cut_ff       <= cut_in;
         wbank_ff     <= wbank_in;
         emit_rem_ff  <= emit_rem_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Word details wait here for the automaton's verdict, then move to the emitter.
   always_ff @(posedge clock) begin
      if (finish) begin
         flen_ff  <= len_ff;
         fcut_ff  <= cut_ff;
         fbank_ff <= wbank_ff;
      end
      if (emit_load) begin
         emit_bank_ff <= fbank_ff;
         emit_cut_ff  <= fcut_ff;
      end
      if (rd_en) begin
         rsp_last_ff <= emit_rem_ff == LENW'(1);
         rsp_cut_ff  <= emit_cut_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[{wbank_ff, len_eff[LW-1:0]}] <= ch;
      end
      if (rd_en) begin
         buf_rd_ff <= buf_mem[{emit_bank_ff, emit_idx_ff}];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_word_char    = buf_rd_ff;
   assign rsp_last_of_word = rsp_last_ff;
   assign rsp_word_cut     = rsp_cut_ff;

   // A verdict only arrives when the emitter has nothing left to read.
   `ASSERT_SAME(a_load_idle, dstat.done, emit_rem_ff == '0)
   // The filling bank never collides with the bank being read out.
   `ASSERT_SAME(a_bank_split, buf_we && (emit_rem_ff != '0), wbank_ff != emit_bank_ff)
   // Every accepted word end produces a verdict in the next cycle.
   `ASSERT_NEXT(a_verdict, finish, dstat.done)

endmodule

`default_nettype wire
